FILE: src/psr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the periodic slope relaxation core
// no dependencies

package psr_pkg;

  localparam int GRID_MAX_SIDE_DEF = 64;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_RELAX = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] REG_SIDE  = 2'd0;
  localparam logic [1:0] REG_RISE  = 2'd1;
  localparam logic [1:0] REG_TOL   = 2'd2;
  localparam logic [1:0] REG_LIMIT = 2'd3;

  localparam logic [6:0]  SIDE_RST  = 7'd64;
  localparam logic [30:0] RISE_RST  = 31'd65536;
  localparam logic [15:0] TOL_RST   = 16'd3;
  localparam logic [19:0] LIMIT_RST = 20'd100000;

  localparam logic [2:0] PH_LAST = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SW,
    ST_AP
  } state_t;

endpackage

FILE: src/psr_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies

module psr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/periodic_slope_relaxation_core.sv
`timescale 1ns / 1ps
// top level of the periodic slope relaxation core
// depends on psr_pkg and psr_ram
//
// A load beat gives no result; a read beat gives one result. A relax beat
// keeps the block busy: each sweep visits every cell in turn with five reads
// of the single height ram read port (the cell and its right, left, down and
// up neighbours), and a sweep that finds a steep interface is followed by an
// apply pass over every cell. A run ends when a sweep finds no steep
// interface or when the sweep count reaches the limit. The next beat is
// taken once the result beat has been taken.

module periodic_slope_relaxation_core #(
  parameter int GRID_MAX_SIDE = psr_pkg::GRID_MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // cell_index[11:0], elevation_in[43:12]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // elevation_out[31:0], sweeps_used[51:32]
  output logic        out_tuser,  // converged[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int DEPTH = GRID_MAX_SIDE * GRID_MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(GRID_MAX_SIDE + 1);
  localparam int CW0   = 2 * NW;
  localparam int CW    = (CW0 > 12) ? CW0 : 12;
  localparam int CHW   = 35;

  psr_pkg::state_t state_r, state_nxt;

  logic [6:0]  side_r;
  logic [30:0] rise_r;
  logic [15:0] tol_r;
  logic [19:0] limit_r;

  logic [NW-1:0]  n;
  logic [CW-1:0]  cells, last_base;

  logic [NW-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [CW-1:0]  rb_r, rb_nxt;
  logic [2:0]     ph_r, ph_nxt;
  logic [CW-1:0]  apk_r, apk_nxt;
  logic           apph_r, apph_nxt;
  logic           steep_r, steep_nxt;
  logic [19:0]    cnt_r, cnt_nxt;
  logic signed [31:0]    hk_r, hk_nxt;
  logic signed [CHW-1:0] acc_r, acc_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_elev_r, out_elev_nxt;
  logic        out_conv_r, out_conv_nxt;
  logic [19:0] out_sw_r, out_sw_nxt;

  logic [1:0]  kind;
  logic [CW-1:0] idx;
  logic        in_acc, idx_ok;

  logic          h_we, c_we;
  logic [AW-1:0] h_waddr, h_raddr, c_addr;
  logic [31:0]   h_wdata, h_rdata;
  logic [CHW-1:0] c_rdata;

  // neighbour addressing
  logic [NW-1:0] col_r1, col_l1;
  logic [CW-1:0] db, ub, k_addr, nb_addr;

  // shared interface unit
  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic signed [33:0] excess;
  logic               steep_now;
  logic signed [CHW-1:0] flux;

  // apply unit
  logic signed [35:0] sum_v;
  logic [31:0]        sat_v;

  assign cfg_ready  = 1'b1;
  assign kind       = in_tuser;
  assign idx        = CW'(in_tdata[11:0]);
  assign in_tready  = (state_r == psr_pkg::ST_IDLE) && !out_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_conv_r;
  assign out_tdata  = {4'b0, out_sw_r, out_elev_r};

  always_comb begin
    if (side_r == 7'd0) begin
      n = NW'(1);
    end else if (32'(side_r) > GRID_MAX_SIDE) begin
      n = NW'(GRID_MAX_SIDE);
    end else begin
      n = NW'(side_r);
    end
  end

  assign cells     = CW'(CW'(n) * CW'(n));
  assign last_base = cells - CW'(n);
  assign idx_ok    = idx < cells;

  assign col_r1  = (col_r == n - NW'(1)) ? '0 : col_r + NW'(1);
  assign col_l1  = (col_r == '0) ? n - NW'(1) : col_r - NW'(1);
  assign db      = (row_r == n - NW'(1)) ? '0 : rb_r + CW'(n);
  assign ub      = (row_r == '0) ? last_base : rb_r - CW'(n);
  assign k_addr  = rb_r + CW'(col_r);

  always_comb begin
    case (ph_r)
      3'd1:    nb_addr = rb_r + CW'(col_r1);
      3'd2:    nb_addr = rb_r + CW'(col_l1);
      3'd3:    nb_addr = db + CW'(col_r);
      3'd4:    nb_addr = ub + CW'(col_r);
      default: nb_addr = k_addr;
    endcase
  end

  assign diff      = {hk_r[31], hk_r} - {h_rdata[31], h_rdata};
  assign mag       = diff[32] ? 33'(-diff) : 33'(diff);
  assign excess    = $signed({1'b0, mag}) - $signed({3'b0, rise_r});
  assign steep_now = excess > $signed({18'b0, tol_r});
  assign flux      = $signed({5'b0, excess[31:2]});

  assign sum_v = $signed({{4{h_rdata[31]}}, h_rdata}) + $signed({c_rdata[CHW-1], c_rdata});
  always_comb begin
    if (sum_v > 36'sh07FFFFFFF) begin
      sat_v = 32'h7FFFFFFF;
    end else if (sum_v < -36'sh080000000) begin
      sat_v = 32'h80000000;
    end else begin
      sat_v = sum_v[31:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psr_pkg::ST_IDLE: begin
        if (in_acc && kind == psr_pkg::KIND_READ && idx_ok) begin
          state_nxt = psr_pkg::ST_RD;
        end else if (in_acc && kind == psr_pkg::KIND_RELAX && limit_r != '0) begin
          state_nxt = psr_pkg::ST_SW;
        end
      end
      psr_pkg::ST_RD: state_nxt = psr_pkg::ST_IDLE;
      psr_pkg::ST_SW: begin
        if (ph_r == psr_pkg::PH_LAST && col_r == n - NW'(1) && row_r == n - NW'(1)) begin
          state_nxt = steep_nxt ? psr_pkg::ST_AP : psr_pkg::ST_IDLE;
        end
      end
      psr_pkg::ST_AP: begin
        if (apph_r && apk_r == cells - CW'(1)) begin
          state_nxt = (cnt_r + 20'd1 == limit_r) ? psr_pkg::ST_IDLE : psr_pkg::ST_SW;
        end
      end
      default: state_nxt = psr_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    rb_nxt = rb_r;
    ph_nxt = ph_r;
    apk_nxt = apk_r;
    apph_nxt = apph_r;
    steep_nxt = steep_r;
    cnt_nxt = cnt_r;
    hk_nxt = hk_r;
    acc_nxt = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_elev_nxt = out_elev_r;
    out_conv_nxt = out_conv_r;
    out_sw_nxt = out_sw_r;
    h_we = 1'b0;
    h_waddr = idx[AW-1:0];
    h_wdata = in_tdata[43:12];
    h_raddr = idx[AW-1:0];
    c_we = 1'b0;
    c_addr = k_addr[AW-1:0];
    case (state_r)
      psr_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (kind)
            psr_pkg::KIND_LOAD: h_we = idx_ok;
            psr_pkg::KIND_READ: begin
              if (!idx_ok) begin
                out_valid_nxt = 1'b1;
                out_elev_nxt = '0;
                out_conv_nxt = 1'b0;
                out_sw_nxt = '0;
              end
            end
            psr_pkg::KIND_RELAX: begin
              cnt_nxt = '0;
              steep_nxt = 1'b0;
              col_nxt = '0;
              row_nxt = '0;
              rb_nxt = '0;
              ph_nxt = '0;
              if (limit_r == '0) begin
                out_valid_nxt = 1'b1;
                out_elev_nxt = '0;
                out_conv_nxt = 1'b0;
                out_sw_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      psr_pkg::ST_RD: begin
        out_valid_nxt = 1'b1;
        out_elev_nxt = h_rdata;
        out_conv_nxt = 1'b0;
        out_sw_nxt = '0;
      end
      psr_pkg::ST_SW: begin
        h_raddr = nb_addr[AW-1:0];
        ph_nxt = ph_r + 3'd1;
        if (ph_r == 3'd1) begin
          hk_nxt = $signed(h_rdata);
          acc_nxt = '0;
        end else if (ph_r != 3'd0) begin
          if (steep_now) begin
            steep_nxt = 1'b1;
            acc_nxt = (!diff[32] && diff != '0) ? acc_r - flux : acc_r + flux;
          end
        end
        if (ph_r == psr_pkg::PH_LAST) begin
          c_we = 1'b1;
          ph_nxt = '0;
          if (col_r == n - NW'(1)) begin
            col_nxt = '0;
            if (row_r == n - NW'(1)) begin
              row_nxt = '0;
              rb_nxt = '0;
              apk_nxt = '0;
              apph_nxt = 1'b0;
              if (!steep_nxt) begin
                out_valid_nxt = 1'b1;
                out_elev_nxt = '0;
                out_conv_nxt = 1'b1;
                out_sw_nxt = cnt_r;
              end
            end else begin
              row_nxt = row_r + NW'(1);
              rb_nxt = rb_r + CW'(n);
            end
          end else begin
            col_nxt = col_r + NW'(1);
          end
        end
      end
      psr_pkg::ST_AP: begin
        h_raddr = apk_r[AW-1:0];
        c_addr = apk_r[AW-1:0];
        h_waddr = apk_r[AW-1:0];
        h_wdata = sat_v;
        apph_nxt = !apph_r;
        if (apph_r) begin
          h_we = 1'b1;
          apk_nxt = apk_r + CW'(1);
          if (apk_r == cells - CW'(1)) begin
            cnt_nxt = cnt_r + 20'd1;
            steep_nxt = 1'b0;
            ph_nxt = '0;
            if (cnt_r + 20'd1 == limit_r) begin
              out_valid_nxt = 1'b1;
              out_elev_nxt = '0;
              out_conv_nxt = 1'b0;
              out_sw_nxt = limit_r;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psr_pkg::ST_IDLE;
      side_r <= psr_pkg::SIDE_RST;
      rise_r <= psr_pkg::RISE_RST;
      tol_r <= psr_pkg::TOL_RST;
      limit_r <= psr_pkg::LIMIT_RST;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      steep_r <= 1'b0;
      ph_r <= '0;
      apph_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
      steep_r <= steep_nxt;
      ph_r <= ph_nxt;
      apph_r <= apph_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          psr_pkg::REG_SIDE:  side_r <= cfg_data[6:0];
          psr_pkg::REG_RISE:  rise_r <= cfg_data[30:0];
          psr_pkg::REG_TOL:   tol_r <= cfg_data[15:0];
          psr_pkg::REG_LIMIT: limit_r <= cfg_data[19:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    row_r <= row_nxt;
    rb_r <= rb_nxt;
    apk_r <= apk_nxt;
    hk_r <= hk_nxt;
    acc_r <= acc_nxt;
    out_elev_r <= out_elev_nxt;
    out_conv_r <= out_conv_nxt;
    out_sw_r <= out_sw_nxt;
  end

  psr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_height (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  psr_ram #(.WIDTH(CHW), .DEPTH(DEPTH)) u_change (
    .clk(clk), .we(c_we), .waddr(c_addr), .wdata(acc_nxt),
    .raddr(c_addr), .rdata(c_rdata)
  );

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != psr_pkg::ST_IDLE) |-> !in_tready)
    else $error("input ready while busy");

  a_sweeps_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psr_pkg::ST_SW || state_r == psr_pkg::ST_AP) |-> (cnt_r < limit_r))
    else $error("sweep count reached limit while running");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psr_pkg::ST_SW) |-> (ph_r <= psr_pkg::PH_LAST))
    else $error("cell phase out of range");

  a_result_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psr_pkg::ST_RD) |=> out_tvalid)
    else $error("read gave no result");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for periodic_slope_relaxation_core: directed and random beats,
// checked against an in-bench predictor of the elevation grid; depends on psr_pkg

module tb;

  typedef struct packed {
    logic [31:0] elev;
    logic        conv;
    logic [19:0] sweeps;
  } cell_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  periodic_slope_relaxation_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [6:0]  side_reg;
  logic [30:0] rise_reg;
  logic [15:0] tol_reg;
  logic [19:0] limit_reg;
  int          heights [4096];
  bit          written [4096];
  longint      moves [4096];

  cell_result_t pending_q [$];
  int  mismatches = 0;
  int  burst_left = 0;
  int  stall_mode = 0;
  bit  hold_req = 0;
  int  hold_cnt = 0;

  function automatic int side_used();
    if (side_reg == 0) return 1;
    if (side_reg > psr_pkg::GRID_MAX_SIDE_DEF) return psr_pkg::GRID_MAX_SIDE_DEF;
    return side_reg;
  endfunction

  function automatic bit edge_move(int a, int b);
    longint diff, mag, excess, flux;
    diff = longint'(heights[a]) - longint'(heights[b]);
    mag = diff < 0 ? -diff : diff;
    excess = mag - longint'(rise_reg);
    if (excess <= longint'(tol_reg)) return 0;
    flux = excess >>> 2;
    if (diff > 0) begin
      moves[a] -= flux;
      moves[b] += flux;
    end else begin
      moves[a] += flux;
      moves[b] -= flux;
    end
    return 1;
  endfunction

  function automatic cell_result_t predict_relax();
    cell_result_t res;
    int n, k;
    bit steep;
    longint v;
    n = side_used();
    res = '0;
    while (res.sweeps < limit_reg) begin
      steep = 0;
      for (k = 0; k < n * n; k++) moves[k] = 0;
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) begin
          k = r * n + c;
          steep |= edge_move(k, r * n + (c + 1) % n);
          steep |= edge_move(k, ((r + 1) % n) * n + c);
        end
      if (!steep) begin
        res.conv = 1'b1;
        break;
      end
      for (k = 0; k < n * n; k++) begin
        v = longint'(heights[k]) + moves[k];
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        heights[k] = int'(v);
      end
      res.sweeps++;
    end
    return res;
  endfunction

  function automatic void predict_beat(logic [1:0] kind, int idx, logic [31:0] elev);
    cell_result_t res;
    int cells;
    cells = side_used() * side_used();
    res = '0;
    case (kind)
      psr_pkg::KIND_LOAD: begin
        if (idx < cells) begin
          heights[idx] = elev;
          written[idx] = 1;
        end
      end
      psr_pkg::KIND_RELAX: begin
        res = predict_relax();
        pending_q = {pending_q, res};
      end
      psr_pkg::KIND_READ: begin
        if (idx < cells) res.elev = heights[idx];
        pending_q = {pending_q, res};
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] kind, int idx, logic [31:0] elev);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'b0, elev, idx[11:0]};
    do @(posedge clk); while (!in_tready);
    predict_beat(kind, idx, elev);
    burst_left--;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      psr_pkg::REG_SIDE:  side_reg = value[6:0];
      psr_pkg::REG_RISE:  rise_reg = value[30:0];
      psr_pkg::REG_TOL:   tol_reg = value[15:0];
      psr_pkg::REG_LIMIT: limit_reg = value[19:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(int side, logic [31:0] rise, int tol, int limit);
    wait_idle();
    write_reg(psr_pkg::REG_SIDE, side);
    write_reg(psr_pkg::REG_RISE, rise);
    write_reg(psr_pkg::REG_TOL, tol);
    write_reg(psr_pkg::REG_LIMIT, limit);
  endtask

  // every cell in use must hold a loaded value before a relax
  task automatic fill_grid(bit random_only);
    int cells;
    cells = side_used() * side_used();
    for (int k = 0; k < cells; k++)
      if (random_only || !written[k]) send_item(psr_pkg::KIND_LOAD, k, $urandom());
  endtask

  task automatic test_edges_default();
    send_item(psr_pkg::KIND_LOAD, 0, 32'h7fffffff);
    send_item(psr_pkg::KIND_LOAD, 4095, 32'h80000000);
    send_item(psr_pkg::KIND_READ, 0, 32'hffffffff);
    send_item(psr_pkg::KIND_READ, 4095, 0);
  endtask

  task automatic test_side_one();
    set_regs(0, 32'h7fffffff, 65535, 20'hfffff);
    send_item(psr_pkg::KIND_LOAD, 0, 32'h12345678);
    send_item(psr_pkg::KIND_LOAD, 1, 32'hdeadbeef);
    send_item(psr_pkg::KIND_READ, 1, 0);
    send_item(psr_pkg::KIND_RELAX, 0, 0);
    send_item(psr_pkg::KIND_READ, 0, 0);
    send_item(2'd3, 0, 32'hffffffff);
    send_item(2'd3, 4095, 0);
  endtask

  task automatic test_side_two();
    set_regs(2, 0, 3, 0);
    for (int k = 0; k < 4; k++) send_item(psr_pkg::KIND_LOAD, k, 32'h00010000);
    send_item(psr_pkg::KIND_RELAX, 0, 0);
    set_regs(2, 0, 3, 20'hfffff);
    send_item(psr_pkg::KIND_RELAX, 0, 0);
    set_regs(2, 0, 3, 3);
    send_item(psr_pkg::KIND_LOAD, 0, 32'h7fffffff);
    send_item(psr_pkg::KIND_LOAD, 3, 32'h80000000);
    send_item(psr_pkg::KIND_RELAX, 0, 0);
    for (int k = 0; k < 4; k++) send_item(psr_pkg::KIND_READ, k, 0);
  endtask

  task automatic test_full_grid();
    set_regs(127, 32'h7fffffff, 65535, 2);
    send_item(psr_pkg::KIND_LOAD, 4095, $urandom());
    send_item(psr_pkg::KIND_LOAD, 2730, $urandom());
    send_item(psr_pkg::KIND_READ, 4095, 0);
    send_item(psr_pkg::KIND_READ, 2730, 0);
    set_regs(12, 32'h7fffffff, 65535, 2);
    fill_grid(1);
    send_item(psr_pkg::KIND_RELAX, 0, 0);
    send_item(psr_pkg::KIND_READ, 143, 0);
    send_item(psr_pkg::KIND_READ, 77, 0);
    set_regs(12, 0, 3, 1);
    send_item(psr_pkg::KIND_RELAX, 0, 0);
    send_item(psr_pkg::KIND_READ, 50, 0);
  endtask

  task automatic test_backpressure();
    set_regs(4, 32'h00010000, 3, 5);
    fill_grid(0);
    wait_idle();
    hold_req = 1;
    for (int i = 0; i < 40; i++) send_item(psr_pkg::KIND_READ, $urandom_range(0, 15), 0);
    send_item(psr_pkg::KIND_RELAX, 0, 0);
  endtask

  task automatic test_random();
    int cells, idx, pick;
    logic [31:0] rise, elev;
    for (int ph = 0; ph < 8; ph++) begin
      rise = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h40000);
      set_regs($urandom_range(1, 5), rise,
               ($urandom_range(0, 2) == 0) ? $urandom_range(3, 65535) : $urandom_range(3, 64),
               $urandom_range(1, 20));
      stall_mode = ph % 3;
      cells = side_used() * side_used();
      fill_grid(0);
      for (int i = 0; i < 250; i++) begin
        pick = $urandom_range(0, 99);
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, cells - 1);
        elev = ($urandom_range(0, 1) == 0) ? $urandom()
             : $urandom_range(0, 32'h80000) - 32'h40000;
        if (pick < 3) send_item(psr_pkg::KIND_RELAX, 0, 0);
        else if (pick < 5) send_item(2'd3, idx, elev);
        else if (pick < 58) send_item(psr_pkg::KIND_LOAD, idx, elev);
        else if (idx >= cells || written[idx]) send_item(psr_pkg::KIND_READ, idx, 0);
      end
    end
  endtask

  // receiver stall pattern and long hold-off
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt <= 400;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 9) > 2);
        default: out_tready <= ($urandom_range(0, 15) != 0) && ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cell_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.elev = out_tdata[31:0];
      got.sweeps = out_tdata[51:32];
      got.conv = out_tuser;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp elev %h conv %b sweeps %0d, got elev %h conv %b sweeps %0d",
                     want.elev, want.conv, want.sweeps, got.elev, got.conv, got.sweeps);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    side_reg = psr_pkg::SIDE_RST;
    rise_reg = psr_pkg::RISE_RST;
    tol_reg = psr_pkg::TOL_RST;
    limit_reg = psr_pkg::LIMIT_RST;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_edges_default();
    test_side_one();
    test_side_two();
    test_full_grid();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
